FILE: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/irdx_pkg.sv
// shared types, constants and digit encoding for the radix digit converter
package irdx_pkg;

	localparam int unsigned BASE_W = 6;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_LETTER_OFFSET = 8'h37;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		logic load;       // take a new number, clear remainder and digit count
		logic step;       // one multi-bit division step
		logic div_start;  // divide the current quotient again
		logic push;       // store remainder as next digit
		logic rd_init;    // point read index at most significant digit
		logic rd_dec;     // move read index one digit down
		logic out_load;   // place fetched digit into output register
	} irdx_cmd_t;

	typedef struct packed {
		logic positive;
		logic step_last;
		logic quot_zero;
		logic idx_zero;
		logic out_free;
	} irdx_sts_t;

	function automatic logic [7:0] digit_to_ascii(input logic [BASE_W-1:0] d);
		logic [7:0] res;
		if (d < DECIMAL_LIMIT) begin
			res = 8'(d) + CHAR_ZERO;
		end else begin
			res = 8'(d) + CHAR_LETTER_OFFSET;
		end
		return res;
	endfunction

endpackage

FILE: sv/irdx_ram.sv
// generic single-port-write ram with registered read
module irdx_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/irdx_ctrl.sv
// sequencer for division, digit push and most-significant-first readout
module irdx_ctrl import irdx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  irdx_sts_t sts,
	output irdx_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DIV,
		PUSH,
		RD,
		EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			IDLE: begin
				if (in_valid && sts.positive) begin
					cmd.load = 1'b1;
					state_d = DIV;
				end
			end
			DIV: begin
				cmd.step = 1'b1;
				if (sts.step_last) begin
					state_d = PUSH;
				end
			end
			PUSH: begin
				cmd.push = 1'b1;
				if (sts.quot_zero) begin
					cmd.rd_init = 1'b1;
					state_d = RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d = DIV;
				end
			end
			RD: begin
				// ram read data lands next cycle
				state_d = EMIT;
			end
			EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_zero) begin
						state_d = IDLE;
					end else begin
						cmd.rd_dec = 1'b1;
						state_d = RD;
					end
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/irdx_dp.sv
// radix register, iterative divider, digit stack and output register
module irdx_dp import irdx_pkg::*; #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              base_we,
	input  logic [BASE_W-1:0] base_wdata,
	input  logic [31:0]       in_number,
	input  irdx_cmd_t         cmd,
	output irdx_sts_t         sts,
	output logic [7:0]        out_char,
	output logic              out_last,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int unsigned QW = VALUE_BITS - 1;
	localparam int unsigned DIGITS = QW;
	localparam int unsigned AW = $clog2(DIGITS);
	localparam int unsigned CW = $clog2(DIGITS + 1);
	localparam int unsigned NSTEP = 4;
	localparam int unsigned DIV_W = ((QW + NSTEP - 1) / NSTEP) * NSTEP;
	localparam int unsigned STEPS = DIV_W / NSTEP;
	localparam int unsigned SW = $clog2(STEPS);
	localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);

	logic [BASE_W-1:0] base_q;
	logic [DIV_W-1:0]  dq_q;
	logic [BASE_W-1:0] rem_q;
	logic [SW-1:0]     step_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     idx_q;
	logic [BASE_W-1:0] rd_digit;
	logic [63:0]       wide_in;
	logic [VALUE_BITS-1:0] raw;
	logic [DIV_W-1:0]  dq_d;
	logic [BASE_W-1:0] rem_d;
	logic [BASE_W:0]   trial;

	// radix write saturates into the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (base_we) begin
			if (base_wdata < BASE_MIN) begin
				base_q <= BASE_MIN;
			end else if (base_wdata > BASE_MAX) begin
				base_q <= BASE_MAX;
			end else begin
				base_q <= base_wdata;
			end
		end
	end

	assign wide_in = {32'd0, in_number};
	assign raw = wide_in[VALUE_BITS-1:0];

	// restoring division, several quotient bits per cycle
	always_comb begin
		dq_d = dq_q;
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < NSTEP; i++) begin
			trial = {rem_d, dq_d[DIV_W-1]};
			dq_d = {dq_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, base_q}) begin
				trial = trial - {1'b0, base_q};
				dq_d[0] = 1'b1;
			end
			rem_d = trial[BASE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dq_q <= DIV_W'(raw[QW-1:0]);
		end else if (cmd.step) begin
			dq_q <= dq_d;
		end
		if (cmd.load || cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load || cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.rd_init) begin
				idx_q <= cnt_q[AW-1:0];
			end else if (cmd.rd_dec) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	irdx_ram #(
		.WIDTH(BASE_W),
		.DEPTH(DIGITS)
	) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_q),
		.raddr (idx_q),
		.rdata (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char <= digit_to_ascii(rd_digit);
			out_last <= (idx_q == '0);
		end
	end

	always_comb begin
		sts.positive = !raw[VALUE_BITS-1] && (raw != '0);
		sts.step_last = (step_q == STEP_LAST);
		sts.quot_zero = (dq_q == '0);
		sts.idx_zero = (idx_q == '0);
		sts.out_free = !out_valid || out_ready;
	end

endmodule

FILE: sv/integer_to_radix_digits.sv
// top level: signed integer to ascii digits in a configurable radix
// usage:
//   s_axis carries one number per transfer; non-positive numbers are taken
//   and produce nothing. m_axis returns one ascii digit per transfer, most
//   significant first, with tlast on the least significant digit.
//   base_we/base_wdata write the radix; values are clamped to 2..36 and
//   should only change while no conversion is in flight.
// operation:
//   a conversion divides the running quotient by the radix with a
//   restoring divider that retires four quotient bits a cycle; readout
//   then fetches each digit back through the registered stack ram.
//   s_axis_tready is high only between conversions.
// reset:
//   arst_n clears the sequencer and output valid and sets the radix to 10.
//   the digit stack ram needs no clearing.
// stall:
//   the last digit sits in an output register, so the next number is taken
//   while it waits; a stalled m_axis holds readout until it is taken.
module integer_to_radix_digits import irdx_pkg::*; #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              base_we,
	input  logic [BASE_W-1:0] base_wdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // [31:0] number
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [7:0] digit_char
	output logic              m_axis_tlast   // last_digit
);

	`include "assert_macros.svh"

	irdx_cmd_t cmd;
	irdx_sts_t sts;
	logic      in_xfer;
	logic      char_legal;

	irdx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	irdx_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_we    (base_we),
		.base_wdata (base_wdata),
		.in_number  (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_char   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready)
	);

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign char_legal = (m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_NINE) ||
		(m_axis_tdata >= CHAR_UPPER_A && m_axis_tdata <= CHAR_UPPER_Z);

	`ASSERT_IMPLY(a_no_overwrite, cmd.out_load, sts.out_free, "digit overwritten before transfer")
	`ASSERT_IMPLY(a_load_on_accept, cmd.load, in_xfer, "load without input transfer")
	`ASSERT_ALWAYS(a_char_legal, !m_axis_tvalid || char_legal, "illegal digit character")

endmodule

FILE: tb/sv/tb.sv
// testbench for integer_to_radix_digits: random numbers and radix settings, digit scoreboard
module tb import irdx_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned HOLD_CYCLES = 800;
	localparam int unsigned TIMEOUT_NS = 2_000_000;
	localparam int unsigned IDLE_PCT = 37;

	// expected digit stream, rebuilt from each accepted number
	class digit_scoreboard;
		typedef struct {
			logic [7:0] ch;
			logic       last;
		} digit_t;

		logic [BASE_W-1:0] radix;
		digit_t            due_digits[$];
		int                errors;

		function new();
			radix = BASE_RESET;
			errors = 0;
		endfunction

		function void set_radix(logic [BASE_W-1:0] v);
			if (v < BASE_MIN) begin
				radix = BASE_MIN;
			end else if (v > BASE_MAX) begin
				radix = BASE_MAX;
			end else begin
				radix = v;
			end
		endfunction

		// non-positive numbers give no digits
		function void note_number(logic [31:0] n);
			logic [BASE_W-1:0] rems[$];
			logic [31:0]       q;
			logic [BASE_W-1:0] d;
			digit_t            item;
			if (n[31] || n == 0) return;
			q = n;
			while (q != 0) begin
				rems.push_back(BASE_W'(q % radix));
				q = q / radix;
			end
			// remainders come out least significant first
			for (int k = rems.size() - 1; k >= 0; k--) begin
				d = rems[k];
				if (d < DECIMAL_LIMIT) begin
					item.ch = CHAR_ZERO + 8'(d);
				end else begin
					item.ch = CHAR_UPPER_A + 8'(d) - 8'(DECIMAL_LIMIT);
				end
				item.last = (k == 0);
				due_digits.push_back(item);
			end
		endfunction

		function bit idle();
			return due_digits.size() == 0;
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_digit(logic [7:0] ch, logic last);
			digit_t want;
			if (due_digits.size() == 0) begin
				report($sformatf("unexpected digit 0x%02h last %0b", ch, last));
			end else begin
				want = due_digits.pop_front();
				if (ch !== want.ch)
					report($sformatf("digit 0x%02h, want 0x%02h", ch, want.ch));
				if (last !== want.last)
					report($sformatf("tlast %0b, want %0b", last, want.last));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              base_we = 1'b0;
	logic [BASE_W-1:0] base_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;  // [31:0] number
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;       // [7:0] digit_char
	logic              m_axis_tlast;       // last_digit

	bit                quiet = 1'b0;       // no idling on either side
	bit                hold_req = 1'b0;

	digit_scoreboard   sb = new();

	integer_to_radix_digits #(.VALUE_BITS(32)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_we       (base_we),
		.base_wdata    (base_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// digit receiver: random backpressure plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_digit(m_axis_tdata, m_axis_tlast);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task send_number(logic [31:0] v);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			do @(posedge clk); while (!quiet && $urandom_range(99) < IDLE_PCT);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_number(v);
	endtask

	task end_burst();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= $urandom;
	endtask

	// all digits out, then allow for a conversion that yields nothing
	task wait_idle();
		while (!sb.idle()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_base(logic [BASE_W-1:0] v);
		wait_idle();
		base_we <= 1'b1;
		base_wdata <= v;
		@(posedge clk);
		sb.set_radix(v);
		base_we <= 1'b0;
	endtask

	// mostly positive numbers of random magnitude, some zero and negative
	function automatic logic [31:0] pick_number();
		int unsigned pick;
		int unsigned width;
		logic [31:0] v;
		pick = $urandom_range(99);
		if (pick < 12) begin
			v = $urandom | 32'h8000_0000;
		end else if (pick < 17) begin
			v = '0;
		end else begin
			width = $urandom_range(1, 31);
			v = ($urandom & ((32'h1 << width) - 1)) | (32'h1 << (width - 1));
		end
		return v;
	endfunction

	initial begin
		logic [31:0]       dec_cases[] = '{0, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 9, 10, 99, 100, 1000000000};
		logic [31:0]       b36_cases[] = '{35, 36, 1295, 32'h7FFF_FFFF};
		logic [31:0]       bin_cases[] = '{1, 2, 32'h7FFF_FFFF, 32'h4000_0000};
		logic [BASE_W-1:0] plan[] = '{6'd16, 6'd37, 6'd2, 6'd63, 6'd8, 6'd1, 6'd36,
			6'd10, 6'd0, 6'd0};
		int unsigned       nitems;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: radix 10 out of reset, then 36 and 2 (the latter from a write of 0)
		foreach (dec_cases[i]) send_number(dec_cases[i]);
		end_burst();
		write_base(6'd36);
		foreach (b36_cases[i]) send_number(b36_cases[i]);
		end_burst();
		write_base(6'd0);
		foreach (bin_cases[i]) send_number(bin_cases[i]);
		end_burst();

		foreach (plan[p]) begin
			write_base((p >= 8) ? BASE_W'($urandom_range(0, 63)) : plan[p]);
			quiet = (p == 3);
			if (p == 5) hold_req = 1'b1;
			nitems = $urandom_range(20, 30);
			repeat (nitems) send_number(pick_number());
			end_burst();
		end
		quiet = 1'b0;

		wait_idle();
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/irdx_pkg.sv
sv/irdx_ram.sv
sv/irdx_ctrl.sv
sv/irdx_dp.sv
sv/integer_to_radix_digits.sv
tb/sv/tb.sv
